// ----- design/ktir_pkg.sv -----
// shared constants, types and command codes for the table interpolation resampler
package ktir_pkg;

   // table geometry
   localparam int MAX_ENTRIES     = 16;
   localparam int ENT_W           = $clog2(MAX_ENTRIES);
   localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
   localparam int MAX_SRC_SAMPLES = 256;
   localparam int SRC_W           = $clog2(MAX_SRC_SAMPLES);
   localparam int STORE_DEPTH     = MAX_ENTRIES * MAX_SRC_SAMPLES;
   localparam int STORE_AW        = ENT_W + SRC_W;
   localparam int MAX_OUT_SAMPLES = 64;
   localparam int OUT_W           = $clog2(MAX_OUT_SAMPLES);

   // fixed point and fill tracking
   localparam int FRAC_BITS = 30;
   localparam int FILL_W    = 9;
   localparam logic [FILL_W-1:0] FILL_CLOSED = 9'd511;
   localparam logic [31:0] FAST_STEP_RESET = 32'd167772;

   // divider operand widths
   localparam int DVD_W = 64;
   localparam int DVS_W = 32;
   localparam int DCNT_W = $clog2(DVD_W);

   // front to back queue
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_HEADER = 2'd1,
      OP_APPEND = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] key;
      logic [31:0] step;
      logic [7:0]  lags;
      logic [31:0] sample;
   } cmd_type;

   typedef struct packed {
      logic [DVD_W-1:0] quot;
      logic [DVS_W-1:0] rem;
      logic             done;
   } div_res_type;

endpackage

// ----- design/kernel_table_interp_resampler.sv -----
// top level of the table interpolation resampler
//
//  channel | direction | handshake             | content
//  req_    | in        | req_valid/req_ready   | op, key, entry step, entry lags, sample
//  rsp_    | out       | rsp_valid/rsp_ready   | sample, lag index, last, status
//  csr_    | in        | csr_wr_en             | fast step (Q8.24)
//
// loads (clear, header, append) run one per cycle while the back end is idle
// queries: linear key search, then per entry a run-length division unless steps match;
//   per output point an index pick, up to two divisions, sample reads and multiply,
//   a blend when the key lies between entries, and the emit; the shared bit-serial
//   divider sets the pace
// reset is synchronous; tables and sample store hold no reset value, no clearing pass
// a four-item queue parts the front from the back; results wait in an output register
module kernel_table_interp_resampler (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [15:0]         req_fn_value,
   input  logic [31:0]         req_entry_step,
   input  logic [7:0]          req_entry_lags,
   input  logic signed [31:0]  req_sample_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_sample_out,
   output logic [5:0]          rsp_lag_index,
   output logic                rsp_last,
   output logic [1:0]          rsp_status,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data
);
   import ktir_pkg::*;

   cmd_type q_cmd;
   logic    q_valid;
   logic    q_pop;

   // accept and classify
   ktir_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_fn_value   (req_fn_value),
      .req_entry_step (req_entry_step),
      .req_entry_lags (req_entry_lags),
      .req_sample_in  (req_sample_in),
      .q_cmd          (q_cmd),
      .q_valid        (q_valid),
      .q_pop          (q_pop)
   );

   // execute
   ktir_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_cmd          (q_cmd),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_lag_index  (rsp_lag_index),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

// ----- design/ktir_front.sv -----
// front end: accepts items, classifies them and queues them for the back end
module ktir_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [15:0]          req_fn_value,
   input  logic [31:0]          req_entry_step,
   input  logic [7:0]           req_entry_lags,
   input  logic signed [31:0]   req_sample_in,
   output ktir_pkg::cmd_type    q_cmd,
   output logic                 q_valid,
   input  logic                 q_pop
);
   import ktir_pkg::*;

   cmd_type         queue_ff [Q_DEPTH];
   cmd_type         cmd_in;
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;
   logic            push;

   // classify the item into a command, keep the key and only the other fields its op uses
   always_comb begin
      cmd_in        = '0;
      cmd_in.op     = op_type'(req_op);
      cmd_in.key    = req_fn_value;
      if (op_type'(req_op) == OP_HEADER) begin
         cmd_in.step = req_entry_step;
         cmd_in.lags = req_entry_lags;
      end
      if (op_type'(req_op) == OP_APPEND) begin
         cmd_in.sample = req_sample_in;
      end
   end

   assign req_ready = (count_ff != (Q_AW+1)'(Q_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- design/ktir_div.sv -----
// shared restoring divider, one quotient bit per cycle
module ktir_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ktir_pkg::DVD_W-1:0]  dividend,
   input  logic [ktir_pkg::DVS_W-1:0]  divisor,
   output ktir_pkg::div_res_type       res
);
   import ktir_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [DVS_W:0]     trial, diff;
   logic               fits;

   // one restoring step
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == DCNT_W'(DVD_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign res.quot = dvd_ff;
   assign res.rem  = rem_ff;
   assign res.done = done_ff;

endmodule

// ----- design/ktir_back.sv -----
// back end: table state, loads, query search, resampling, blending and result register
module ktir_back (
   input  logic                clock,
   input  logic                reset,
   input  ktir_pkg::cmd_type   q_cmd,
   input  logic                q_valid,
   output logic                q_pop,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_sample_out,
   output logic [5:0]          rsp_lag_index,
   output logic                rsp_last,
   output logic [1:0]          rsp_status
);
   import ktir_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE   = 18'h00001,
      ST_EMPTY  = 18'h00002,
      ST_SEARCH = 18'h00004,
      ST_KDIV   = 18'h00008,
      ST_SETUP  = 18'h00010,
      ST_TG     = 18'h00020,
      ST_TGDIV  = 18'h00040,
      ST_POINT  = 18'h00080,
      ST_DIV1   = 18'h00100,
      ST_DIV2   = 18'h00200,
      ST_RD0    = 18'h00400,
      ST_RD1    = 18'h00800,
      ST_RD2    = 18'h01000,
      ST_MUL0   = 18'h02000,
      ST_MUL1   = 18'h04000,
      ST_SUM    = 18'h08000,
      ST_HRD    = 18'h10000,
      ST_EMIT   = 18'h20000
   } state_type;

   localparam logic [30:0] ONE_Q30 = 31'(64'd1 << FRAC_BITS);

   function automatic logic [SRC_W-1:0] clamp_idx(input logic [DVD_W-1:0] v);
      logic [SRC_W-1:0] r;
      r = (v > DVD_W'(MAX_SRC_SAMPLES - 1)) ? SRC_W'(MAX_SRC_SAMPLES - 1) : v[SRC_W-1:0];
      return r;
   endfunction

   state_type state_ff, state_in;

   // configuration and table state
   logic [31:0]        fast_step_ff, fast_step_in;
   logic [CNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [FILL_W-1:0]  fill_count_ff, fill_count_in;
   logic [7:0]         last_lags_ff, last_lags_in;
   logic [15:0]        key_table_ff  [MAX_ENTRIES];
   logic [31:0]        step_table_ff [MAX_ENTRIES];
   logic [7:0]         lags_table_ff [MAX_ENTRIES];
   logic [31:0]        store_mem [STORE_DEPTH];
   logic [31:0]        st_q_ff;
   logic signed [31:0] hirun_mem [MAX_OUT_SAMPLES];
   logic signed [31:0] hr_q_ff;

   // query working registers
   logic [15:0]         key_ff, key_in;
   logic [CNT_W-1:0]    srch_ff, srch_in;
   logic [15:0]         prevk_ff, prevk_in;
   logic [ENT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, ent_ff, ent_in;
   logic                blend_ff, blend_in;
   logic                pass_hi_ff, pass_hi_in;
   logic                mix_blend_ff, mix_blend_in;
   logic [30:0]         akey_ff, akey_in, amix_ff, amix_in;
   logic                sat_ff, sat_in;
   logic [OUT_W-1:0]    nlast_ff, nlast_in, nhi_last_ff, nhi_last_in, j_ff, j_in;
   logic [31:0]         step_ff, step_in;
   logic [7:0]          lags_ff, lags_in;
   logic [39:0]         tmem_ff, tmem_in;
   logic                same_ff, same_in;
   logic [SRC_W-1:0]    idx0_ff, idx0_in, idx1_ff, idx1_in;
   logic signed [31:0]  s0_ff, s0_in, s1_ff, s1_in, v_ff, v_in;
   logic signed [63:0]  p0_ff, p0_in, p1_ff, p1_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  out_sample_ff, out_sample_in;
   logic [OUT_W-1:0]    out_lag_ff, out_lag_in;
   logic                out_last_ff, out_last_in;
   logic [1:0]          out_status_ff, out_status_in;

   // helpers
   logic [31:0]          fs_eff;
   logic [OUT_W+31:0]    t_val;
   logic [15:0]          kt, kdiff_lo, kdiff_hi;
   logic [DVD_W-1:0]     tg_raw;
   logic                 tg_sat;
   logic [OUT_W-1:0]     tg_last;
   logic [30:0]          one_minus;
   logic signed [63:0]   acc, rnd;
   logic signed [31:0]   vsum;
   logic [OUT_W-1:0]     hr_idx;
   logic                 out_free;
   logic                 tbl_we, st_we, hr_we;
   logic [STORE_AW-1:0]  st_waddr, st_raddr;
   logic                 div_start;
   logic [DVD_W-1:0]     div_dvd;
   logic [DVS_W-1:0]     div_dvs;
   div_res_type          div_res;

   ktir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .res      (div_res)
   );

   // datapath helpers
   always_comb begin
      fs_eff    = (fast_step_ff == '0) ? 32'd1 : fast_step_ff;
      t_val     = (OUT_W+32)'(j_ff) * (OUT_W+32)'(fs_eff);
      kt        = key_table_ff[srch_ff[ENT_W-1:0]];
      kdiff_lo  = key_ff - prevk_ff;
      kdiff_hi  = kt - prevk_ff;
      one_minus = ONE_Q30 - amix_ff;
      acc       = p0_ff + p1_ff;
      rnd       = acc + (64'sd1 <<< (FRAC_BITS - 1));
      vsum      = 32'(rnd >>> FRAC_BITS);
      hr_idx    = (j_ff > nhi_last_ff) ? nhi_last_ff : j_ff;
      out_free  = !rsp_valid_ff || rsp_ready;
      if (state_ff == ST_TG) begin
         tg_raw = DVD_W'(lags_ff);
      end else begin
         tg_raw = (div_res.quot == '0) ? DVD_W'(1) : div_res.quot;
      end
      tg_sat  = (tg_raw > DVD_W'(MAX_OUT_SAMPLES - 1));
      tg_last = tg_sat ? OUT_W'(MAX_OUT_SAMPLES - 1) : tg_raw[OUT_W-1:0];
      st_waddr = {ENT_W'(entry_count_ff - CNT_W'(1)), fill_count_ff[SRC_W-1:0]};
      st_raddr = (state_ff == ST_RD1) ? {ent_ff, idx1_ff} : {ent_ff, idx0_ff};
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      fast_step_in   = csr_wr_en ? csr_wr_data : fast_step_ff;
      entry_count_in = entry_count_ff;
      fill_count_in  = fill_count_ff;
      last_lags_in   = last_lags_ff;
      key_in         = key_ff;
      srch_in        = srch_ff;
      prevk_in       = prevk_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      ent_in         = ent_ff;
      blend_in       = blend_ff;
      pass_hi_in     = pass_hi_ff;
      mix_blend_in   = mix_blend_ff;
      akey_in        = akey_ff;
      amix_in        = amix_ff;
      sat_in         = sat_ff;
      nlast_in       = nlast_ff;
      nhi_last_in    = nhi_last_ff;
      j_in           = j_ff;
      step_in        = step_ff;
      lags_in        = lags_ff;
      tmem_in        = tmem_ff;
      same_in        = same_ff;
      idx0_in        = idx0_ff;
      idx1_in        = idx1_ff;
      s0_in          = s0_ff;
      s1_in          = s1_ff;
      v_in           = v_ff;
      p0_in          = p0_ff;
      p1_in          = p1_ff;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;
      out_sample_in  = out_sample_ff;
      out_lag_in     = out_lag_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;
      q_pop          = 1'b0;
      tbl_we         = 1'b0;
      st_we          = 1'b0;
      hr_we          = 1'b0;
      div_start      = 1'b0;
      div_dvd        = '0;
      div_dvs        = step_ff;

      unique case (state_ff)
         // loads complete in this state, queries start their search or go to the empty result
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_CLEAR: begin
                     entry_count_in = '0;
                     fill_count_in  = '0;
                  end
                  OP_HEADER: begin
                     if (entry_count_ff < CNT_W'(MAX_ENTRIES)) begin
                        tbl_we         = 1'b1;
                        entry_count_in = entry_count_ff + CNT_W'(1);
                        fill_count_in  = '0;
                        last_lags_in   = q_cmd.lags;
                     end else begin
                        fill_count_in = FILL_CLOSED;
                     end
                  end
                  OP_APPEND: begin
                     if (entry_count_ff != '0 &&
                         fill_count_ff < ({1'b0, last_lags_ff} + FILL_W'(1)) &&
                         fill_count_ff < FILL_W'(MAX_SRC_SAMPLES)) begin
                        st_we         = 1'b1;
                        fill_count_in = fill_count_ff + FILL_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     key_in   = q_cmd.key;
                     srch_in  = '0;
                     prevk_in = '0;
                     state_in = (entry_count_ff == '0) ? ST_EMPTY : ST_SEARCH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // empty table gives a single flagged item
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_sample_in = '0;
               out_lag_in    = '0;
               out_last_in   = 1'b1;
               out_status_in = STATUS_EMPTY;
               state_in      = ST_IDLE;
            end
         end
         // linear search for the first key at or above the query
         ST_SEARCH: begin
            if (srch_ff == entry_count_ff || kt >= key_ff) begin
               pass_hi_in = 1'b0;
               blend_in   = 1'b0;
               if (entry_count_ff == CNT_W'(1) || srch_ff == '0) begin
                  lo_in    = '0;
                  ent_in   = '0;
                  state_in = ST_SETUP;
               end else if (srch_ff == entry_count_ff) begin
                  lo_in    = ENT_W'(entry_count_ff - CNT_W'(1));
                  ent_in   = ENT_W'(entry_count_ff - CNT_W'(1));
                  state_in = ST_SETUP;
               end else begin
                  lo_in     = ENT_W'(srch_ff - CNT_W'(1));
                  hi_in     = srch_ff[ENT_W-1:0];
                  blend_in  = 1'b1;
                  div_start = 1'b1;
                  div_dvd   = DVD_W'(kdiff_lo) << FRAC_BITS;
                  div_dvs   = DVS_W'(kdiff_hi);
                  state_in  = ST_KDIV;
               end
            end else begin
               prevk_in = kt;
               srch_in  = srch_ff + CNT_W'(1);
            end
         end
         // key fraction, then resample the upper entry first
         ST_KDIV: begin
            if (div_res.done) begin
               akey_in    = div_res.quot[30:0];
               ent_in     = hi_ff;
               pass_hi_in = 1'b1;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            step_in  = step_table_ff[ent_ff];
            lags_in  = lags_table_ff[ent_ff];
            tmem_in  = 40'(step_table_ff[ent_ff]) * 40'(lags_table_ff[ent_ff]);
            same_in  = (step_table_ff[ent_ff] == fs_eff);
            state_in = ST_TG;
         end
         // run length: lags when steps match, else ceil(tmem / fast step), at least one; clamped to 63
         ST_TG: begin
            if (same_ff) begin
               if (pass_hi_ff) begin
                  nhi_last_in = tg_last;
               end else begin
                  nlast_in = tg_last;
                  sat_in   = tg_sat;
               end
               j_in     = '0;
               state_in = ST_POINT;
            end else begin
               div_start = 1'b1;
               div_dvd   = DVD_W'(tmem_ff) + DVD_W'(fs_eff) - DVD_W'(1);
               div_dvs   = fs_eff;
               state_in  = ST_TGDIV;
            end
         end
         ST_TGDIV: begin
            if (div_res.done) begin
               if (pass_hi_ff) begin
                  nhi_last_in = tg_last;
               end else begin
                  nlast_in = tg_last;
                  sat_in   = tg_sat;
               end
               j_in     = '0;
               state_in = ST_POINT;
            end
         end
         // pick source indexes for this point
         ST_POINT: begin
            mix_blend_in = 1'b0;
            amix_in      = '0;
            if (same_ff) begin
               idx0_in  = clamp_idx(DVD_W'(j_ff));
               idx1_in  = clamp_idx(DVD_W'(j_ff));
               state_in = ST_RD0;
            end else if (t_val == '0) begin
               idx0_in  = '0;
               idx1_in  = '0;
               state_in = ST_RD0;
            end else if (40'(t_val) >= tmem_ff) begin
               idx0_in  = clamp_idx(DVD_W'(lags_ff));
               idx1_in  = clamp_idx(DVD_W'(lags_ff));
               state_in = ST_RD0;
            end else begin
               div_start = 1'b1;
               div_dvd   = DVD_W'(t_val);
               state_in  = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_res.done) begin
               idx0_in   = clamp_idx(div_res.quot);
               idx1_in   = clamp_idx(div_res.quot + DVD_W'(1));
               div_start = 1'b1;
               div_dvd   = DVD_W'(div_res.rem) << FRAC_BITS;
               state_in  = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_res.done) begin
               amix_in  = div_res.quot[30:0];
               state_in = ST_RD0;
            end
         end
         // fetch both neighbor samples
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            s0_in    = $signed(st_q_ff);
            state_in = ST_RD2;
         end
         ST_RD2: begin
            s1_in    = $signed(st_q_ff);
            state_in = ST_MUL0;
         end
         // weighted sum, with a multiply in MUL0 and another in MUL1
         ST_MUL0: begin
            p0_in    = s0_ff * $signed({1'b0, one_minus});
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            p1_in    = s1_ff * $signed({1'b0, amix_ff});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            v_in = vsum;
            if (mix_blend_ff) begin
               state_in = ST_EMIT;
            end else if (pass_hi_ff) begin
               hr_we = 1'b1;
               if (j_ff == nhi_last_ff) begin
                  ent_in     = lo_ff;
                  pass_hi_in = 1'b0;
                  state_in   = ST_SETUP;
               end else begin
                  j_in     = j_ff + OUT_W'(1);
                  state_in = ST_POINT;
               end
            end else if (blend_ff) begin
               state_in = ST_HRD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         // blend with the upper series, which holds its last point
         ST_HRD: begin
            s0_in        = v_ff;
            s1_in        = hr_q_ff;
            amix_in      = akey_ff;
            mix_blend_in = 1'b1;
            state_in     = ST_MUL0;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_sample_in = v_ff;
               out_lag_in    = j_ff;
               out_last_in   = (j_ff == nlast_ff);
               out_status_in = sat_ff ? STATUS_SAT : STATUS_OK;
               mix_blend_in  = 1'b0;
               if (j_ff == nlast_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + OUT_W'(1);
                  state_in = ST_POINT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fast_step_ff   <= FAST_STEP_RESET;
         entry_count_ff <= '0;
         fill_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         mix_blend_ff   <= 1'b0;
         pass_hi_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fast_step_ff   <= fast_step_in;
         entry_count_ff <= entry_count_in;
         fill_count_ff  <= fill_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         mix_blend_ff   <= mix_blend_in;
         pass_hi_ff     <= pass_hi_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_lags_ff  <= last_lags_in;
      key_ff        <= key_in;
      srch_ff       <= srch_in;
      prevk_ff      <= prevk_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      ent_ff        <= ent_in;
      blend_ff      <= blend_in;
      akey_ff       <= akey_in;
      amix_ff       <= amix_in;
      sat_ff        <= sat_in;
      nlast_ff      <= nlast_in;
      nhi_last_ff   <= nhi_last_in;
      j_ff          <= j_in;
      step_ff       <= step_in;
      lags_ff       <= lags_in;
      tmem_ff       <= tmem_in;
      same_ff       <= same_in;
      idx0_ff       <= idx0_in;
      idx1_ff       <= idx1_in;
      s0_ff         <= s0_in;
      s1_ff         <= s1_in;
      v_ff          <= v_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      out_sample_ff <= out_sample_in;
      out_lag_ff    <= out_lag_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   // entry tables
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         key_table_ff[entry_count_ff[ENT_W-1:0]]  <= q_cmd.key;
         step_table_ff[entry_count_ff[ENT_W-1:0]] <= q_cmd.step;
         lags_table_ff[entry_count_ff[ENT_W-1:0]] <= q_cmd.lags;
      end
   end

   // sample store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= q_cmd.sample;
      end
      st_q_ff <= store_mem[st_raddr];
   end

   // upper series buffer
   always_ff @(posedge clock) begin
      if (hr_we) begin
         hirun_mem[j_ff] <= vsum;
      end
      hr_q_ff <= hirun_mem[hr_idx];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_lag_index  = out_lag_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_status     = out_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_status_ff == STATUS_EMPTY |-> out_last_ff && out_lag_ff == '0)
      else $error("empty table result not a single last item");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_dvs != '0)
      else $error("divider started with zero divisor");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free && j_ff == nlast_ff |=> state_ff == ST_IDLE)
      else $error("run did not end after its last item");

endmodule

// ----- tb/kernel_table_interp_resampler_tb.sv -----
// testbench for the table interpolation resampler: directed table, random loads and queries
module kernel_table_interp_resampler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ktir_pkg::*;

   localparam int STALL_LIMIT = 150000;
   localparam int SETTLE_CYCLES = 400;
   localparam longint ONE_Q30 = 64'sd1 << FRAC_BITS;

   typedef struct {
      logic signed [31:0] sample;
      logic [5:0]         lag;
      logic               last;
      logic [1:0]         status;
   } point_type;

   typedef struct {
      cmd_type   cmd;
      bit        typed;
      point_type pt;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = OP_CLEAR;
   logic [15:0] req_fn_value = '0;
   logic [31:0] req_entry_step = '0;
   logic [7:0] req_entry_lags = '0;
   logic signed [31:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_sample_out;
   logic [5:0] rsp_lag_index;
   logic rsp_last;
   logic [1:0] rsp_status;
   logic csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // shadow copy of the block state
   logic [31:0] fast_step_m;
   int unsigned entries_m;
   int unsigned fill_m;
   logic [15:0] key_tab [0:MAX_ENTRIES-1];
   logic [31:0] step_tab [0:MAX_ENTRIES-1];
   logic [7:0] lags_tab [0:MAX_ENTRIES-1];
   logic signed [31:0] sample_mem [0:STORE_DEPTH-1];

   point_type run_q [$];
   int errors = 0;
   int tx_idle = 0;
   int rx_stall = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_cnt = 0;
   int items_sent = 0;

   kernel_table_interp_resampler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_fn_value(req_fn_value), .req_entry_step(req_entry_step),
      .req_entry_lags(req_entry_lags), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .rsp_lag_index(rsp_lag_index), .rsp_last(rsp_last), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // source sample read with the store slot clamp
   function automatic longint src_sample(int unsigned e, longint unsigned idx);
      if (idx > MAX_SRC_SAMPLES - 1) idx = MAX_SRC_SAMPLES - 1;
      return longint'(sample_mem[e * MAX_SRC_SAMPLES + idx]);
   endfunction

   // weighted sum with a q0.30 weight, rounded half up
   function automatic longint lerp_q30(longint s0, longint s1, longint unsigned w);
      longint acc;
      longint unsigned biased;
      acc = s0 * (ONE_Q30 - longint'(w)) + s1 * longint'(w);
      biased = acc + (64'd1 << 61);
      biased = (biased + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return longint'(biased) - (64'sd1 << 31);
   endfunction

   // one entry resampled at the fast step
   task automatic resample_entry(input int unsigned e, output longint pts [0:MAX_OUT_SAMPLES-1],
                                 output int unsigned n, output bit sat);
      longint unsigned stp, lg, fs, tmem, tg, t;
      bit same;
      stp = step_tab[e];
      lg = lags_tab[e];
      fs = (fast_step_m == 0) ? 1 : fast_step_m;
      tmem = stp * lg;
      same = (stp == fs);
      sat = 0;
      if (same) tg = lg;
      else begin
         tg = (tmem + fs - 1) / fs;
         if (tg < 1) tg = 1;
      end
      if (tg > MAX_OUT_SAMPLES - 1) begin
         tg = MAX_OUT_SAMPLES - 1;
         sat = 1;
      end
      for (int j = 0; j <= tg; j++) begin
         t = longint'(j) * fs;
         if (same) pts[j] = src_sample(e, j);
         else if (t == 0) pts[j] = src_sample(e, 0);
         else if (t >= tmem) pts[j] = src_sample(e, lg);
         else pts[j] = lerp_q30(src_sample(e, t / stp), src_sample(e, t / stp + 1),
                                ((t % stp) << FRAC_BITS) / stp);
      end
      n = 32'(tg + 1);
   endtask

   // apply one accepted item to the shadow state, queue the run it causes
   task automatic predict_item(input cmd_type c);
      longint lo_pts [0:MAX_OUT_SAMPLES-1];
      longint hi_pts [0:MAX_OUT_SAMPLES-1];
      int unsigned n_lo, n_hi, lo, hi, i;
      bit sat, sat_hi, blend;
      longint unsigned w;
      longint v;
      point_type pt;
      blend = 0;
      hi = 0;
      n_hi = 0;
      w = 0;
      case (c.op)
         OP_CLEAR: begin
            entries_m = 0;
            fill_m = 0;
         end
         OP_HEADER: begin
            if (entries_m < MAX_ENTRIES) begin
               key_tab[entries_m] = c.key;
               step_tab[entries_m] = c.step;
               lags_tab[entries_m] = c.lags;
               entries_m++;
               fill_m = 0;
            end else fill_m = FILL_CLOSED;
         end
         OP_APPEND: begin
            if (entries_m > 0 && fill_m < lags_tab[entries_m-1] + 1 &&
                fill_m < MAX_SRC_SAMPLES) begin
               sample_mem[(entries_m - 1) * MAX_SRC_SAMPLES + fill_m] = c.sample;
               fill_m++;
            end
         end
         default: begin
            if (entries_m == 0) begin
               pt.sample = 0;
               pt.lag = 0;
               pt.last = 1;
               pt.status = STATUS_EMPTY;
               run_q.insert(run_q.size(), pt);
            end else begin
               for (i = 0; i < entries_m; i++)
                  if (key_tab[i] >= c.key) break;
               if (entries_m == 1 || i == 0) lo = 0;
               else if (i == entries_m) lo = entries_m - 1;
               else begin
                  lo = i - 1;
                  hi = i;
                  blend = 1;
                  w = (longint'(c.key - key_tab[lo]) << FRAC_BITS) /
                      longint'(key_tab[hi] - key_tab[lo]);
               end
               resample_entry(lo, lo_pts, n_lo, sat);
               if (blend) resample_entry(hi, hi_pts, n_hi, sat_hi);
               for (int j = 0; j < n_lo; j++) begin
                  v = lo_pts[j];
                  if (blend) v = lerp_q30(v, hi_pts[(j < n_hi) ? j : n_hi - 1], w);
                  pt.sample = v[31:0];
                  pt.lag = j[5:0];
                  pt.last = (j + 1 == n_lo);
                  pt.status = sat ? STATUS_SAT : STATUS_OK;
                  run_q.insert(run_q.size(), pt);
               end
            end
         end
      endcase
   endtask

   // offer one item, hold it until accepted
   task automatic push_req(input cmd_type c, input bit typed, input point_type pt);
      if ($urandom_range(0, 99) < tx_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle);
      end
      req_valid <= 1'b1;
      req_op <= c.op;
      req_fn_value <= c.key;
      req_entry_step <= c.step;
      req_entry_lags <= c.lags;
      req_sample_in <= c.sample;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (typed) run_q.insert(run_q.size(), pt);
      else predict_item(c);
   endtask

   task automatic send_cmd(input op_type op, input logic [15:0] key, input logic [31:0] stp,
                           input logic [7:0] lags, input logic [31:0] smp);
      cmd_type c;
      point_type none;
      c.op = op;
      c.key = key;
      c.step = stp;
      c.lags = lags;
      c.sample = smp;
      push_req(c, 1'b0, none);
   endtask

   // drain the block, then write the fast step
   task automatic write_fast_step(input logic [31:0] value);
      req_valid <= 1'b0;
      while (run_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fast_step_m = value;
   endtask

   // one complete entry, sometimes followed by surplus samples
   task automatic load_entry(input logic [15:0] key);
      int r;
      logic [7:0] lags;
      longint unsigned stp;
      r = $urandom_range(0, 99);
      if (r < 88) lags = 8'($urandom_range(1, 6));
      else if (r < 98) lags = 8'($urandom_range(7, 40));
      else lags = 8'($urandom_range(41, 255));
      r = $urandom_range(0, 99);
      if (r < 15) stp = fast_step_m;
      else if (r < 25) stp = 64'($urandom);
      else if (r < 30) stp = 0;
      else stp = longint'(fast_step_m) * $urandom_range(0, 2) +
                 $urandom_range(0, fast_step_m / 2);
      if (stp > 64'hFFFF_FFFF) stp = 64'hFFFF_FFFF;
      send_cmd(OP_HEADER, key, stp[31:0], lags, '0);
      for (int k = 0; k <= lags; k++) send_cmd(OP_APPEND, '0, $urandom, '0, $urandom);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 2)) send_cmd(OP_APPEND, '0, '0, '0, $urandom);
   endtask

   // random loads and queries until the phase budget is spent
   task automatic random_phase(input int budget);
      int stop_at, r;
      logic [15:0] cursor;
      stop_at = items_sent + budget;
      cursor = 0;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            if ($urandom_range(0, 4) == 0) begin
               send_cmd(OP_CLEAR, 16'($urandom), $urandom, 8'($urandom), $urandom);
               cursor = 0;
            end
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 9) == 0) load_entry(16'($urandom));
               else begin
                  cursor = (cursor > 16'hFFFF - 16'h3000) ? 16'hFFFF
                           : cursor + 16'($urandom_range(1, 16'h3000));
                  load_entry(cursor);
               end
            end
            repeat ($urandom_range(1, 2))
               send_cmd(OP_QUERY, $urandom_range(0, 1) ? 16'($urandom)
                                                       : 16'($urandom_range(0, cursor)),
                        $urandom, 8'($urandom), $urandom);
         end else if (r < 85) begin
            // header with a short fill, thrown away by a clear
            send_cmd(OP_HEADER, 16'($urandom), $urandom, 8'($urandom_range(3, 255)),
                     $urandom);
            repeat ($urandom_range(0, 2)) send_cmd(OP_APPEND, '0, '0, '0, $urandom);
            send_cmd(OP_CLEAR, '0, '0, '0, '0);
            cursor = 0;
         end else if (r < 93) begin
            // headers past a full table are ignored and close appends
            while (entries_m < MAX_ENTRIES) load_entry(16'($urandom));
            send_cmd(OP_HEADER, 16'($urandom), $urandom, 8'($urandom), '0);
            send_cmd(OP_APPEND, '0, '0, '0, $urandom);
            send_cmd(OP_QUERY, 16'($urandom), '0, '0, '0);
         end else
            send_cmd(OP_QUERY, 16'($urandom), $urandom, 8'($urandom), $urandom);
      end
   endtask

   // result check
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (run_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result sample %h lag %0d last %b status %0d", $time,
                     rsp_sample_out, rsp_lag_index, rsp_last, rsp_status);
         end else begin
            want = run_q.pop_front();
            if (rsp_sample_out !== want.sample) begin
               errors++;
               $display("%0t: sample_out expected %h actual %h", $time, want.sample,
                        rsp_sample_out);
            end
            if (rsp_lag_index !== want.lag) begin
               errors++;
               $display("%0t: lag_index expected %0d actual %0d", $time, want.lag,
                        rsp_lag_index);
            end
            if (rsp_last !== want.last) begin
               errors++;
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
            end
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else rsp_ready <= ($urandom_range(0, 99) >= rx_stall);
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("kernel_table_interp_resampler_tb: done, errors");
         $finish;
      end
   end

   // directed rows: loads and queries covering extremes and special cases
   row_type rows [] = '{
      '{'{OP_QUERY, 16'h1000, 32'd0, 8'd0, 32'd0}, 1, '{32'sd0, 6'd0, 1'b1, STATUS_EMPTY}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h7FFF_FFFF}, 0, '{0, 0, 0, 0}},
      '{'{OP_HEADER, 16'h0000, 32'd167772, 8'd3, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h7FFF_FFFF}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h8000_0000}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'hFFFF_FFFF}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h0001_0000}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h1234_5678}, 0, '{0, 0, 0, 0}},
      '{'{OP_QUERY, 16'h0000, 32'd0, 8'd0, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_HEADER, 16'hF000, 32'hFFFF_FFFF, 8'd2, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h7FFF_FFFF}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h8000_0000}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h5555_5555}, 0, '{0, 0, 0, 0}},
      '{'{OP_QUERY, 16'h8000, 32'd0, 8'd0, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_HEADER, 16'hF800, 32'd0, 8'd1, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'hDEAD_BEEF}, 0, '{0, 0, 0, 0}},
      '{'{OP_APPEND, 16'h0, 32'd0, 8'd0, 32'h0000_0001}, 0, '{0, 0, 0, 0}},
      '{'{OP_QUERY, 16'hF400, 32'd0, 8'd0, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_QUERY, 16'hFFFF, 32'd0, 8'd0, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_CLEAR, 16'h0, 32'd0, 8'd0, 32'd0}, 0, '{0, 0, 0, 0}},
      '{'{OP_QUERY, 16'hFFFF, 32'd0, 8'd0, 32'd0}, 1, '{32'sd0, 6'd0, 1'b1, STATUS_EMPTY}}
   };

   // main sequence
   initial begin
      fast_step_m = FAST_STEP_RESET;
      entries_m = 0;
      fill_m = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) push_req(rows[r].cmd, rows[r].typed, rows[r].pt);

      // long receiver hold while queries keep coming
      load_entry(16'h0100);
      load_entry(16'h0900);
      hold_request = 2000;
      repeat (10) send_cmd(OP_QUERY, 16'($urandom_range(0, 16'h0A00)), '0, '0, '0);
      random_phase(40);

      write_fast_step(32'h0100_0000);
      tx_idle = 81;
      random_phase(50);

      write_fast_step(32'd1);
      tx_idle = 0;
      rx_stall = 81;
      random_phase(40);

      write_fast_step(32'hFFFF_FFFF);
      tx_idle = 23;
      rx_stall = 23;
      random_phase(50);

      write_fast_step(FAST_STEP_RESET);
      random_phase(50);

      req_valid <= 1'b0;
      while (run_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) $display("kernel_table_interp_resampler_tb: done, clean");
      else $display("kernel_table_interp_resampler_tb: done, errors");
      $finish;
   end

endmodule
